// ===== rtl/affine_warp_address_generator_top_assert.svh =====
// Assertion macros for the affine warp address generator
`ifndef AFFINE_WARP_ADDRESS_GENERATOR_TOP_ASSERT_SVH
`define AFFINE_WARP_ADDRESS_GENERATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define AWAG_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("awag assertion failed");
`define AWAG_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("awag assertion failed");
`else
`define AWAG_ASSERT_CLK(label, clk, rst_n, prop)
`define AWAG_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== rtl/awag_pkg.sv =====
// Shared types, constants and helpers for the affine warp address generator
`timescale 1ns / 1ps
`default_nettype none
package awag_pkg;
    localparam int FRAC_BITS = 16;
    localparam int MAX_DIM   = 4096;
    localparam int COEF_W    = 32;
    localparam int DIM_W     = 13;
    localparam int COORD_W   = 12;
    localparam int OUT_W     = 16;
    localparam int SUM_W     = 48;
    localparam int IDX_W     = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_M00        = 3'd0,
        REG_M01        = 3'd1,
        REG_M10        = 3'd2,
        REG_M11        = 3'd3,
        REG_M20        = 3'd4,
        REG_M21        = 3'd5,
        REG_IMAGE_ROWS = 3'd6,
        REG_IMAGE_COLS = 3'd7
    } reg_idx_t;

    typedef logic [5:0][COEF_W-1:0] mat_t;

    typedef struct packed {
        logic busy;
        logic singular;
    } inv_status_t;

    function automatic logic signed [COEF_W-1:0] trunc_frac(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] q;
        q = s >>> FRAC_BITS;
        if (s[SUM_W-1] && (s[FRAC_BITS-1:0] != '0)) begin
            q = q + SUM_W'(1);
        end
        return q[COEF_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] sat16(input logic signed [COEF_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (v > 32'sd32767) begin
            r = 16'h7fff;
        end else if (v < -32'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/awag_inv.sv =====
// Sequencer that forms the affine inverse with a shared multiplier and a radix-2 divider
`timescale 1ns / 1ps
`default_nettype none
module awag_inv (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  awag_pkg::mat_t        mat,
    output awag_pkg::mat_t        inv,
    output awag_pkg::inv_status_t status
);
    import awag_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MUL   = 4'b0010,
        ST_SETUP = 4'b0100,
        ST_DIV   = 4'b1000
    } state_t;

    state_t      state_reg;
    logic [2:0]  cnt_reg;
    logic [2:0]  idx_reg;
    logic [5:0]  bit_reg;
    logic        sing_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [63:0] det_reg;
    logic [63:0] n20_reg;
    logic [63:0] n21_reg;
    logic [63:0] rem_reg;
    logic [63:0] lo_reg;
    logic [63:0] q_reg;
    logic        neg_reg;
    mat_t        inv_reg;

    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] num;
    logic [63:0] num_mag;
    logic [63:0] det_mag;
    logic [63:0] hi_init;
    logic [63:0] lo_init;
    logic        neg_init;
    logic        sat_early;
    logic [63:0] rem_sh;
    logic        ge;
    logic [63:0] rem_step;
    logic [63:0] q_step;

    function automatic logic [63:0] sext64(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic [31:0] sat32(input logic [63:0] q, input logic neg);
        logic [31:0] r;
        if (!neg) begin
            r = (q > 64'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
        end else begin
            r = (q >= 64'h8000_0000) ? 32'h8000_0000 : (~q[31:0]) + 32'd1;
        end
        return r;
    endfunction

    always_comb begin
        unique case (cnt_reg)
            3'd0:    begin op_x = mat[REG_M00]; op_y = mat[REG_M11]; end
            3'd1:    begin op_x = mat[REG_M01]; op_y = mat[REG_M10]; end
            3'd2:    begin op_x = mat[REG_M10]; op_y = mat[REG_M21]; end
            3'd3:    begin op_x = mat[REG_M11]; op_y = mat[REG_M20]; end
            3'd4:    begin op_x = mat[REG_M01]; op_y = mat[REG_M20]; end
            3'd5:    begin op_x = mat[REG_M00]; op_y = mat[REG_M21]; end
            default: begin op_x = '0; op_y = '0; end
        endcase
    end

    always_comb begin
        unique case (idx_reg)
            3'd0:    num = sext64(mat[REG_M11]);
            3'd1:    num = 64'd0 - sext64(mat[REG_M01]);
            3'd2:    num = 64'd0 - sext64(mat[REG_M10]);
            3'd3:    num = sext64(mat[REG_M00]);
            3'd4:    num = n20_reg;
            3'd5:    num = n21_reg;
            default: num = '0;
        endcase
    end

    assign num_mag   = num[63] ? 64'd0 - num : num;
    assign det_mag   = det_reg[63] ? 64'd0 - det_reg : det_reg;
    assign neg_init  = num[63] ^ det_reg[63];
    assign hi_init   = (idx_reg < 3'd4) ? (num_mag >> 32) : (num_mag >> 48);
    assign lo_init   = (idx_reg < 3'd4) ? (num_mag << 32) : (num_mag << 16);
    assign sat_early = hi_init >= det_mag;
    assign rem_sh    = {rem_reg[62:0], lo_reg[63]};
    assign ge        = rem_sh >= det_mag;
    assign rem_step  = ge ? rem_sh - det_mag : rem_sh;
    assign q_step    = {q_reg[62:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_MUL;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            bit_reg   <= '0;
            sing_reg  <= 1'b0;
        end else if (start) begin
            state_reg <= ST_MUL;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                end
                ST_MUL: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd6) begin
                        idx_reg <= '0;
                        if (det_reg == '0) begin
                            state_reg <= ST_IDLE;
                            sing_reg  <= 1'b1;
                        end else begin
                            state_reg <= ST_SETUP;
                            sing_reg  <= 1'b0;
                        end
                    end
                end
                ST_SETUP: begin
                    bit_reg <= '0;
                    if (sat_early) begin
                        if (idx_reg == 3'd5) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg <= idx_reg + 3'd1;
                        end
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    bit_reg <= bit_reg + 6'd1;
                    if (bit_reg == 6'd63) begin
                        if (idx_reg == 3'd5) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_SETUP;
                            idx_reg   <= idx_reg + 3'd1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 64'($signed(op_x) * $signed(op_y));
        unique case (state_reg)
            ST_MUL: begin
                unique case (cnt_reg)
                    3'd1, 3'd3, 3'd5: acc_reg <= prod_reg;
                    3'd2:             det_reg <= acc_reg - prod_reg;
                    3'd4:             n20_reg <= acc_reg - prod_reg;
                    3'd6:             n21_reg <= acc_reg - prod_reg;
                    default: begin
                    end
                endcase
            end
            ST_SETUP: begin
                rem_reg <= hi_init;
                lo_reg  <= lo_init;
                q_reg   <= '0;
                neg_reg <= neg_init;
                if (sat_early) begin
                    inv_reg[idx_reg] <= sat32({64{1'b1}}, neg_init);
                end
            end
            ST_DIV: begin
                rem_reg <= rem_step;
                lo_reg  <= {lo_reg[62:0], 1'b0};
                q_reg   <= q_step;
                if (bit_reg == 6'd63) begin
                    inv_reg[idx_reg] <= sat32(q_step, neg_reg);
                end
            end
            default: begin
            end
        endcase
    end

    assign inv             = inv_reg;
    assign status.busy     = state_reg != ST_IDLE;
    assign status.singular = sing_reg;
endmodule
`default_nettype wire

// ===== rtl/awag_map.sv =====
// Five-stage pipeline, one coordinate per cycle unless stalled, via selected matrix
`timescale 1ns / 1ps
`default_nettype none
`include "affine_warp_address_generator_top_assert.svh"
module awag_map (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  awag_pkg::mat_t                      mat,
    input  awag_pkg::mat_t                      inv,
    input  awag_pkg::inv_status_t               inv_st,
    input  logic [awag_pkg::DIM_W-1:0]          image_rows,
    input  logic [awag_pkg::DIM_W-1:0]          image_cols,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [awag_pkg::COORD_W-1:0]        s_row,
    input  logic [awag_pkg::COORD_W-1:0]        s_col,
    input  logic                                s_backward,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [awag_pkg::OUT_W-1:0]          m_read_row,
    output logic [awag_pkg::OUT_W-1:0]          m_read_col,
    output logic [awag_pkg::OUT_W-1:0]          m_write_row,
    output logic [awag_pkg::OUT_W-1:0]          m_write_col,
    output logic                                m_in_range,
    output logic                                m_singular
);
    import awag_pkg::*;

    logic adv;
    logic accept;

    logic [COEF_W-1:0] sel_a, sel_b, sel_c, sel_d, sel_e, sel_f;
    logic signed [SUM_W-1:0] p_ra, p_rb, p_cc, p_cd;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic back1_reg, back2_reg, back3_reg, back4_reg;
    logic sing1_reg, sing2_reg, sing3_reg, sing4_reg;
    logic [COORD_W-1:0] row1_reg, row2_reg, row3_reg, row4_reg;
    logic [COORD_W-1:0] col1_reg, col2_reg, col3_reg, col4_reg;
    logic signed [SUM_W-1:0] pra1_reg, prb1_reg, pcc1_reg, pcd1_reg, pcc2_reg, pcd2_reg;
    logic [COEF_W-1:0] e1_reg, f1_reg, e2_reg, f2_reg, e3_reg, f3_reg;
    logic signed [COEF_W-1:0] tr2_reg, tc2_reg, tr3_reg, tc3_reg, tr4_reg, tc4_reg;

    logic [OUT_W-1:0] rrow_reg, rcol_reg, wrow_reg, wcol_reg;
    logic inr_reg, sing5_reg;

    logic [DIM_W-1:0] rows_cap, cols_cap;
    logic signed [COEF_W-1:0] rows_lim, cols_lim;
    logic inr;
    logic [OUT_W-1:0] row_o, col_o, tr_o, tc_o;

    assign adv     = !v5_reg || m_ready;
    assign s_ready = adv && !inv_st.busy;
    assign accept  = s_valid && s_ready;

    assign sel_a = s_backward ? inv[REG_M00] : mat[REG_M00];
    assign sel_b = s_backward ? inv[REG_M01] : mat[REG_M01];
    assign sel_c = s_backward ? inv[REG_M10] : mat[REG_M10];
    assign sel_d = s_backward ? inv[REG_M11] : mat[REG_M11];
    assign sel_e = s_backward ? inv[REG_M20] : mat[REG_M20];
    assign sel_f = s_backward ? inv[REG_M21] : mat[REG_M21];

    assign p_ra = $signed({1'b0, s_row}) * $signed(sel_a);
    assign p_rb = $signed({1'b0, s_row}) * $signed(sel_b);
    assign p_cc = $signed({1'b0, s_col}) * $signed(sel_c);
    assign p_cd = $signed({1'b0, s_col}) * $signed(sel_d);

    assign rows_cap = (image_rows > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_rows;
    assign cols_cap = (image_cols > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_cols;
    assign rows_lim = $signed({{(COEF_W-DIM_W){1'b0}}, rows_cap});
    assign cols_lim = $signed({{(COEF_W-DIM_W){1'b0}}, cols_cap});

    assign inr = !sing4_reg && !tr4_reg[COEF_W-1] && !tc4_reg[COEF_W-1]
                 && (tr4_reg < rows_lim) && (tc4_reg < cols_lim);
    assign row_o = {{(OUT_W-COORD_W){1'b0}}, row4_reg};
    assign col_o = {{(OUT_W-COORD_W){1'b0}}, col4_reg};
    assign tr_o  = sing4_reg ? '0 : sat16(tr4_reg);
    assign tc_o  = sing4_reg ? '0 : sat16(tc4_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            back1_reg <= s_backward;
            sing1_reg <= s_backward && inv_st.singular;
            row1_reg  <= s_row;
            col1_reg  <= s_col;
            pra1_reg  <= p_ra;
            prb1_reg  <= p_rb;
            pcc1_reg  <= p_cc;
            pcd1_reg  <= p_cd;
            e1_reg    <= sel_e;
            f1_reg    <= sel_f;

            back2_reg <= back1_reg;
            sing2_reg <= sing1_reg;
            row2_reg  <= row1_reg;
            col2_reg  <= col1_reg;
            tr2_reg   <= trunc_frac(pra1_reg);
            tc2_reg   <= trunc_frac(prb1_reg);
            pcc2_reg  <= pcc1_reg;
            pcd2_reg  <= pcd1_reg;
            e2_reg    <= e1_reg;
            f2_reg    <= f1_reg;

            back3_reg <= back2_reg;
            sing3_reg <= sing2_reg;
            row3_reg  <= row2_reg;
            col3_reg  <= col2_reg;
            tr3_reg   <= trunc_frac($signed({tr2_reg, {FRAC_BITS{1'b0}}}) + pcc2_reg);
            tc3_reg   <= trunc_frac($signed({tc2_reg, {FRAC_BITS{1'b0}}}) + pcd2_reg);
            e3_reg    <= e2_reg;
            f3_reg    <= f2_reg;

            back4_reg <= back3_reg;
            sing4_reg <= sing3_reg;
            row4_reg  <= row3_reg;
            col4_reg  <= col3_reg;
            tr4_reg   <= trunc_frac($signed({tr3_reg, {FRAC_BITS{1'b0}}})
                         + $signed({{(SUM_W-COEF_W){e3_reg[COEF_W-1]}}, e3_reg}));
            tc4_reg   <= trunc_frac($signed({tc3_reg, {FRAC_BITS{1'b0}}})
                         + $signed({{(SUM_W-COEF_W){f3_reg[COEF_W-1]}}, f3_reg}));

            sing5_reg <= sing4_reg;
            inr_reg   <= inr;
            rrow_reg  <= back4_reg ? tr_o : row_o;
            rcol_reg  <= back4_reg ? tc_o : col_o;
            wrow_reg  <= back4_reg ? row_o : tr_o;
            wcol_reg  <= back4_reg ? col_o : tc_o;
        end
    end

    assign m_valid     = v5_reg;
    assign m_read_row  = rrow_reg;
    assign m_read_col  = rcol_reg;
    assign m_write_row = wrow_reg;
    assign m_write_col = wcol_reg;
    assign m_in_range  = inr_reg;
    assign m_singular  = sing5_reg;

    `AWAG_ASSERT_CLK(a_singular_blocks, aclk, aresetn, m_valid && m_singular |-> !m_in_range && m_read_row == '0 && m_read_col == '0)
    `AWAG_ASSERT_CLK(a_in_range_nonneg, aclk, aresetn, m_valid && m_in_range |-> !m_read_row[OUT_W-1] && !m_read_col[OUT_W-1] && !m_write_row[OUT_W-1] && !m_write_col[OUT_W-1])
    `AWAG_ASSERT_NORST(a_reset_empties, aclk, !aresetn |=> !m_valid && !v1_reg)
endmodule
`default_nettype wire

// ===== rtl/affine_warp_address_generator_top.sv =====
// Throughput one item per cycle while m_ready takes results and no inverse rebuild is busy.
// The multiply and truncate chain runs in five register stages that stall together.
// After reset and after each write to a matrix register the inverse is rebuilt on one
// 32x32 multiplier and a one-bit-per-cycle divider, with s_ready low; a singular matrix
// skips the divider and returns to idle once the products are formed.
// Reset (aresetn, synchronous, active low) loads the identity matrix and 4096x4096 size.
`timescale 1ns / 1ps
`default_nettype none
module affine_warp_address_generator_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [awag_pkg::IDX_W-1:0]    cfg_index,
    input  logic [awag_pkg::COEF_W-1:0]   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [awag_pkg::COORD_W-1:0]  s_row,
    input  logic [awag_pkg::COORD_W-1:0]  s_col,
    input  logic                          s_backward,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [awag_pkg::OUT_W-1:0]    m_read_row,
    output logic [awag_pkg::OUT_W-1:0]    m_read_col,
    output logic [awag_pkg::OUT_W-1:0]    m_write_row,
    output logic [awag_pkg::OUT_W-1:0]    m_write_col,
    output logic                          m_in_range,
    output logic                          m_singular
);
    import awag_pkg::*;

    mat_t             mat_reg;
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    mat_t             inv;
    inv_status_t      inv_st;
    logic             inv_start;
    reg_idx_t         widx;

    assign widx      = reg_idx_t'(cfg_index);
    assign inv_start = cfg_wr_en && (widx != REG_IMAGE_ROWS) && (widx != REG_IMAGE_COLS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_reg  <= {COEF_W'(0), COEF_W'(0), COEF_W'(1 << FRAC_BITS),
                         COEF_W'(0), COEF_W'(0), COEF_W'(1 << FRAC_BITS)};
            rows_reg <= DIM_W'(MAX_DIM);
            cols_reg <= DIM_W'(MAX_DIM);
        end else if (cfg_wr_en) begin
            unique case (widx)
                REG_IMAGE_ROWS: rows_reg <= cfg_data[DIM_W-1:0];
                REG_IMAGE_COLS: cols_reg <= cfg_data[DIM_W-1:0];
                default:        mat_reg[cfg_index] <= cfg_data;
            endcase
        end
    end

    awag_inv u_inv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (inv_start),
        .mat     (mat_reg),
        .inv     (inv),
        .status  (inv_st)
    );

    awag_map u_map (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .mat         (mat_reg),
        .inv         (inv),
        .inv_st      (inv_st),
        .image_rows  (rows_reg),
        .image_cols  (cols_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_row       (s_row),
        .s_col       (s_col),
        .s_backward  (s_backward),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_row  (m_read_row),
        .m_read_col  (m_read_col),
        .m_write_row (m_write_row),
        .m_write_col (m_write_col),
        .m_in_range  (m_in_range),
        .m_singular  (m_singular)
    );
endmodule
`default_nettype wire
